// File: hdl/sawq_pkg.sv
// shared types, sizes and status codes for the slot allocator with wait queue
// no dependencies
`default_nettype none

package sawq_pkg;

    // sizing
    localparam int SLOT_COUNT = 8;
    localparam int FIFO_DEPTH = 16;
    localparam int KEY_WIDTH  = 32;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    // fixed field widths of the request and response words
    localparam int CMD_W       = 1;
    localparam int KEY_FIELD_W = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_FIELD_W = 3;
    localparam int WAIT_CNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_PLACED    = 3'd0,
        STATUS_QUEUED    = 3'd1,
        STATUS_REFUSED   = 3'd2,
        STATUS_RELEASED  = 3'd3,
        STATUS_REFILLED  = 3'd4,
        STATUS_NOT_FOUND = 3'd5
    } status_t;

    typedef logic [KEY_WIDTH-1:0]  key_t;
    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [FILL_W-1:0]     fill_t;

    // slot table update
    typedef struct packed {
        logic      set_en;   // mark busy and write key
        logic      clr_en;   // mark free
        slot_idx_t idx;
    } slot_upd_t;

    // slot table search results
    typedef struct packed {
        logic      free_found;
        slot_idx_t free_idx;
        logic      match_found;
        slot_idx_t match_idx;
    } slot_stat_t;

    // wait fifo control
    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        fill_t fill;
        logic  full;
        logic  empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// File: hdl/sawq_req_if.sv
// request channel: command and key, valid/ready handshake
// depends on sawq_pkg
`default_nettype none

interface sawq_req_if;
    logic                             valid;
    logic                             ready;
    logic [sawq_pkg::CMD_W-1:0]       cmd;
    logic [sawq_pkg::KEY_FIELD_W-1:0] vehicle_key;

    modport source (output valid, output cmd, output vehicle_key, input ready);
    modport sink   (input valid, input cmd, input vehicle_key, output ready);
endinterface

`default_nettype wire

// File: hdl/sawq_rsp_if.sv
// response channel: status, slot, moved key and waiting count
// depends on sawq_pkg
`default_nettype none

interface sawq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [sawq_pkg::STATUS_W-1:0]     status;
    logic [sawq_pkg::SLOT_FIELD_W-1:0] slot_index;
    logic [sawq_pkg::KEY_FIELD_W-1:0]  moved_key;
    logic [sawq_pkg::WAIT_CNT_W-1:0]   waiting_count;

    modport source (output valid, output status, output slot_index, output moved_key,
                    output waiting_count, input ready);
    modport sink   (input valid, input status, input slot_index, input moved_key,
                    input waiting_count, output ready);
endinterface

`default_nettype wire

// File: hdl/sawq_wait_fifo.sv
// circular wait queue: key memory with registered read, head/tail/fill
// depends on sawq_pkg
`default_nettype none

module sawq_wait_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sawq_pkg::fifo_ctrl_t ctrl,
    input  wire sawq_pkg::key_t       push_key,
    output sawq_pkg::key_t            head_key,
    output sawq_pkg::fifo_stat_t      stat
);
    import sawq_pkg::*;

    localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
    localparam fill_t                 FILL_MAX = FILL_W'(FIFO_DEPTH);

    key_t mem [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    fill_t                 fill_reg, fill_next;
    key_t                  rdata_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // single write port at tail, single read port at head
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_key;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign head_key   = rdata_reg;
    assign stat.fill  = fill_reg;
    assign stat.full  = (fill_reg == FILL_MAX);
    assign stat.empty = (fill_reg == '0);

endmodule

`default_nettype wire

// File: hdl/sawq_slot_table.sv
// slot keys with busy bits, lowest-free and lowest-match search
// depends on sawq_pkg
`default_nettype none

module sawq_slot_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sawq_pkg::key_t      find_key,
    input  wire sawq_pkg::slot_upd_t upd,
    input  wire sawq_pkg::key_t      upd_key,
    output sawq_pkg::slot_stat_t     stat
);
    import sawq_pkg::*;

    key_t                  key_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] busy_reg;
    logic [SLOT_COUNT-1:0] busy_next;
    logic [SLOT_COUNT-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit[i] = busy_reg[i] && (key_reg[i] == find_key);
        end
    end

    // priority pick, highest index scanned first so the lowest wins
    always_comb
    begin
        stat = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                stat.free_found = 1'b1;
                stat.free_idx   = SLOT_IDX_W'(i);
            end
            if (hit[i])
            begin
                stat.match_found = 1'b1;
                stat.match_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (upd.set_en)
        begin
            busy_next[upd.idx] = 1'b1;
        end
        else if (upd.clr_en)
        begin
            busy_next[upd.idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.set_en)
        begin
            key_reg[upd.idx] <= upd_key;
        end
    end

endmodule

`default_nettype wire

// File: hdl/slot_allocator_with_wait_queue_core.sv
// top level of the slot allocator with wait queue
// depends on sawq_pkg, sawq_req_if, sawq_rsp_if, sawq_slot_table, sawq_wait_fifo
`default_nettype none

// Allocates keys into a small table of slots. An allocate request takes the
// lowest free slot, or waits in a circular queue when all slots are busy, or
// is refused when that queue is full. A release request frees the lowest busy
// slot holding the key; if keys are waiting, the oldest one moves straight
// into the freed slot. Keys that are only waiting are never matched on
// release. A request is accepted in the idle state, which starts the
// registered read of the queue head from the key memory; the exec state
// then searches the slot table, decides, and writes back the table and the
// queue. One response word comes out per request through an output register,
// so a new request is taken while the previous response still waits; a
// request stays in the exec state only while that register is still full.
// No clearing pass is needed after reset.

module slot_allocator_with_wait_queue_core (
    input  wire logic clk,
    input  wire logic rst_n,
    sawq_req_if.sink  req,
    sawq_rsp_if.source rsp
);
    import sawq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;

    // captured request
    cmd_t cmd_reg;
    key_t key_reg;

    // response register
    logic                    rsp_valid_reg;
    status_t                 status_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [KEY_FIELD_W-1:0]  moved_reg;
    logic [WAIT_CNT_W-1:0]   count_reg;

    logic       accept;
    logic       commit;
    slot_stat_t slot_stat;
    slot_upd_t  slot_upd;
    key_t       slot_wkey;
    fifo_ctrl_t fifo_ctrl;
    fifo_stat_t fifo_stat;
    key_t       head_key;
    fill_t      fill_after;

    // result of the decision
    status_t   status_next;
    slot_idx_t slot_next;
    key_t      moved_next;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    // decide only when the response register can take the word
    assign commit = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    sawq_slot_table u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .find_key (key_reg),
        .upd      (slot_upd),
        .upd_key  (slot_wkey),
        .stat     (slot_stat)
    );

    sawq_wait_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (fifo_ctrl),
        .push_key (key_reg),
        .head_key (head_key),
        .stat     (fifo_stat)
    );

    always_comb
    begin
        slot_upd        = '0;
        slot_wkey       = key_reg;
        fifo_ctrl       = '0;
        fifo_ctrl.rd_en = accept;   // head read lands for the decide cycle
        status_next     = STATUS_NOT_FOUND;
        slot_next       = '0;
        moved_next      = '0;

        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (slot_stat.free_found)
                begin
                    slot_upd.set_en = commit;
                    slot_upd.idx    = slot_stat.free_idx;
                    status_next     = STATUS_PLACED;
                    slot_next       = slot_stat.free_idx;
                end
                else if (fifo_stat.full)
                begin
                    status_next = STATUS_REFUSED;
                end
                else
                begin
                    fifo_ctrl.push = commit;
                    status_next    = STATUS_QUEUED;
                end
            end
            CMD_RELEASE:
            begin
                if (slot_stat.match_found)
                begin
                    slot_upd.idx = slot_stat.match_idx;
                    slot_next    = slot_stat.match_idx;
                    if (!fifo_stat.empty)
                    begin
                        // oldest waiting key takes over the slot
                        slot_upd.set_en = commit;
                        slot_wkey       = head_key;
                        fifo_ctrl.pop   = commit;
                        status_next     = STATUS_REFILLED;
                        moved_next      = head_key;
                    end
                    else
                    begin
                        slot_upd.clr_en = commit;
                        status_next     = STATUS_RELEASED;
                    end
                end
            end
            default:
            begin
                status_next = STATUS_NOT_FOUND;
            end
        endcase
    end

    // queue occupancy as it stands after this request
    always_comb
    begin
        fill_after = fifo_stat.fill;
        if (fifo_ctrl.push)
        begin
            fill_after = fifo_stat.fill + 1'b1;
        end
        else if (fifo_ctrl.pop)
        begin
            fill_after = fifo_stat.fill - 1'b1;
        end
    end

    // state and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            status_reg    <= STATUS_PLACED;
            slot_reg      <= '0;
            moved_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                status_reg <= status_next;
                slot_reg   <= SLOT_FIELD_W'(slot_next);
                moved_reg  <= KEY_FIELD_W'(moved_next);
                count_reg  <= WAIT_CNT_W'(fill_after);
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(req.cmd);
            key_reg <= KEY_WIDTH'(req.vehicle_key);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.slot_index    = slot_reg;
    assign rsp.moved_key     = moved_reg;
    assign rsp.waiting_count = count_reg;

endmodule

`default_nettype wire
